[rtl/utcc_pkg.sv]
// Shared constants, result type and month-offset table for the Unix time / calendar converter.
// No dependencies; used by every other file in rtl/ except utcc_checker.
package utcc_pkg;

    localparam int NSTAGES   = 11;
    localparam int SEC_STAGE = 4;

    localparam int DAY_SH  = 35;
    localparam int HOUR_SH = 21;
    localparam int MIN_SH  = 14;
    localparam int WD_SH   = 19;
    localparam int CENT_SH = 42;
    localparam int YR_SH   = 29;
    localparam int MO_SH   = 19;
    localparam int D25_SH  = 16;

    localparam logic [63:0] DAY_DIV  = 64'd675;
    localparam logic [63:0] HOUR_DIV = 64'd225;
    localparam logic [63:0] MIN_DIV  = 64'd15;
    localparam logic [63:0] WD_DIV   = 64'd7;
    localparam logic [63:0] CENT_DIV = 64'd146097;
    localparam logic [63:0] YR_DIV   = 64'd1461;
    localparam logic [63:0] MO_DIV   = 64'd153;
    localparam logic [63:0] D25_DIV  = 64'd25;

    localparam logic [25:0] DAY_RCP  = 26'(((64'd1 << DAY_SH) + DAY_DIV - 64'd1) / DAY_DIV);
    localparam logic [13:0] HOUR_RCP = 14'(((64'd1 << HOUR_SH) + HOUR_DIV - 64'd1) / HOUR_DIV);
    localparam logic [10:0] MIN_RCP  = 11'(((64'd1 << MIN_SH) + MIN_DIV - 64'd1) / MIN_DIV);
    localparam logic [16:0] WD_RCP   = 17'(((64'd1 << WD_SH) + WD_DIV - 64'd1) / WD_DIV);
    localparam logic [24:0] CENT_RCP = 25'(((64'd1 << CENT_SH) + CENT_DIV - 64'd1) / CENT_DIV);
    localparam logic [18:0] YR_RCP   = 19'(((64'd1 << YR_SH) + YR_DIV - 64'd1) / YR_DIV);
    localparam logic [11:0] MO_RCP   = 12'(((64'd1 << MO_SH) + MO_DIV - 64'd1) / MO_DIV);
    localparam logic [11:0] D25_RCP  = 12'(((64'd1 << D25_SH) + D25_DIV - 64'd1) / D25_DIV);

    // Julian day of 1970-01-01 plus the March-based offset (2440588 + 32044)
    localparam logic [21:0] JDN_MARCH_BASE = 22'd2472632;
    // 32045 + 2440588
    localparam logic [31:0] JDN_UNIX_BASE  = 32'd2472633;
    localparam logic [16:0] WD_BIAS        = 17'd4;
    localparam logic [31:0] SECS_PER_DAY   = 32'd86400;
    localparam logic [15:0] YEAR_BASE      = 16'd6800;

    typedef struct packed {
        logic [31:0] unix_seconds;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [2:0]  weekday;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [7:0]  year;
    } result_t;

    // days before March-based month m: (153 * m + 2) / 5
    function automatic logic [8:0] month_offset(input logic [3:0] m);
        case (m)
            4'd0:    return 9'd0;
            4'd1:    return 9'd31;
            4'd2:    return 9'd61;
            4'd3:    return 9'd92;
            4'd4:    return 9'd122;
            4'd5:    return 9'd153;
            4'd6:    return 9'd184;
            4'd7:    return 9'd214;
            4'd8:    return 9'd245;
            4'd9:    return 9'd275;
            4'd10:   return 9'd306;
            4'd11:   return 9'd337;
            default: return 9'd0;
        endcase
    endfunction

endpackage

[rtl/utcc_ctrl.sv]
// Valid bits and per-stage load enables for the converter pipeline.
// Depends on utcc_pkg (stage count).
module utcc_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_ready,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output logic [utcc_pkg::NSTAGES-1:0] en
);

    logic [utcc_pkg::NSTAGES-1:0] valid_reg;

    // a stage loads when it is empty or its content moves on
    always_comb
    begin
        en[utcc_pkg::NSTAGES-1] = !valid_reg[utcc_pkg::NSTAGES-1] || rsp_ready;
        for (int k = utcc_pkg::NSTAGES - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= req_valid;
            end
            for (int k = 1; k < utcc_pkg::NSTAGES; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign req_ready = en[0];
    assign rsp_valid = valid_reg[utcc_pkg::NSTAGES-1];

endmodule

[rtl/utcc_to_cal.sv]
// Seconds-to-calendar datapath: reciprocal-multiply divisions, at most two products per stage.
// Depends on utcc_pkg (constants, result_t, month_offset).
module utcc_to_cal (
    input  logic                         clk,
    input  logic [utcc_pkg::NSTAGES-1:0] en,
    input  logic [31:0]                  unix_seconds,
    output utcc_pkg::result_t            res
);

    logic [31:0] s0_ut_reg;
    logic [50:0] s0_pday_reg;

    logic [31:0] s1_ut_reg;
    logic [15:0] s1_days_reg;

    logic [31:0] s2_ut_reg;
    logic [16:0] s2_rem_reg;
    logic [23:0] s2_jx_reg;
    logic [16:0] s2_wx_reg;
    logic [33:0] s2_pwd_reg;

    logic [31:0] s3_ut_reg;
    logic [16:0] s3_rem_reg;
    logic [21:0] s3_jday_reg;
    logic [26:0] s3_phr_reg;
    logic [48:0] s3_pcent_reg;
    logic [2:0]  s3_wd_reg;

    logic [31:0] s4_ut_reg;
    logic [16:0] s4_rem_reg;
    logic [21:0] s4_jday_reg;
    logic [4:0]  s4_hour_reg;
    logic [6:0]  s4_cent_reg;
    logic [2:0]  s4_wd_reg;

    logic [31:0] s5_ut_reg;
    logic [11:0] s5_rsec_reg;
    logic [15:0] s5_jcen_reg;
    logic [4:0]  s5_hour_reg;
    logic [6:0]  s5_cent_reg;
    logic [2:0]  s5_wd_reg;

    logic [31:0] s6_ut_reg;
    logic [11:0] s6_rsec_reg;
    logic [15:0] s6_jcen_reg;
    logic [4:0]  s6_hour_reg;
    logic [6:0]  s6_cent_reg;
    logic [2:0]  s6_wd_reg;
    logic [20:0] s6_pmin_reg;
    logic [36:0] s6_pyr_reg;

    logic [31:0] s7_ut_reg;
    logic [11:0] s7_rsec_reg;
    logic [15:0] s7_jcen_reg;
    logic [4:0]  s7_hour_reg;
    logic [6:0]  s7_cent_reg;
    logic [2:0]  s7_wd_reg;
    logic [5:0]  s7_min_reg;
    logic [6:0]  s7_yr_reg;

    logic [31:0] s8_ut_reg;
    logic [5:0]  s8_sec_reg;
    logic [5:0]  s8_min_reg;
    logic [4:0]  s8_hour_reg;
    logic [2:0]  s8_wd_reg;
    logic [6:0]  s8_cent_reg;
    logic [6:0]  s8_yr_reg;
    logic [8:0]  s8_jyr_reg;

    logic [31:0] s9_ut_reg;
    logic [5:0]  s9_sec_reg;
    logic [5:0]  s9_min_reg;
    logic [4:0]  s9_hour_reg;
    logic [2:0]  s9_wd_reg;
    logic [6:0]  s9_cent_reg;
    logic [6:0]  s9_yr_reg;
    logic [8:0]  s9_jyr_reg;
    logic [22:0] s9_pmo_reg;

    utcc_pkg::result_t res_reg;

    logic [15:0] days_c;
    logic [16:0] rem_c;
    logic [23:0] jx_c;
    logic [16:0] wx_c;
    logic [2:0]  wd_c;
    logic [4:0]  hour_c;
    logic [6:0]  cent_c;
    logic [11:0] rsec_c;
    logic [15:0] jcen_c;
    logic [5:0]  min_c;
    logic [6:0]  yr_c;
    logic [5:0]  sec_c;
    logic [8:0]  jyr_c;
    logic [10:0] xmo_c;
    logic [3:0]  mo_c;
    logic        late_c;
    logic [4:0]  day_c;
    logic [3:0]  month_c;
    logic [15:0] year_c;

    always_comb
    begin
        days_c  = 16'(s0_pday_reg >> utcc_pkg::DAY_SH);
        rem_c   = 17'(s1_ut_reg - 32'(s1_days_reg) * utcc_pkg::SECS_PER_DAY);
        jx_c    = {22'(s1_days_reg) + utcc_pkg::JDN_MARCH_BASE, 2'b11};
        wx_c    = 17'(s1_days_reg) + utcc_pkg::WD_BIAS;
        wd_c    = 3'(s2_wx_reg - 17'(s2_pwd_reg >> utcc_pkg::WD_SH) * 17'd7);
        hour_c  = 5'(s3_phr_reg >> utcc_pkg::HOUR_SH);
        cent_c  = 7'(s3_pcent_reg >> utcc_pkg::CENT_SH);
        rsec_c  = 12'(s4_rem_reg - 17'(s4_hour_reg) * 17'd3600);
        jcen_c  = 16'(25'(s4_jday_reg) - ((25'(s4_cent_reg) * 25'd146097) >> 2));
        min_c   = 6'(s6_pmin_reg >> utcc_pkg::MIN_SH);
        yr_c    = 7'(s6_pyr_reg >> utcc_pkg::YR_SH);
        sec_c   = 6'(s7_rsec_reg - 12'(s7_min_reg) * 12'd60);
        jyr_c   = 9'(s7_jcen_reg - 16'((18'(s7_yr_reg) * 18'd1461) >> 2));
        xmo_c   = 11'(s8_jyr_reg) * 11'd5 + 11'd2;
        mo_c    = 4'(s9_pmo_reg >> utcc_pkg::MO_SH);
        late_c  = (mo_c >= 4'd10);
        day_c   = 5'(s9_jyr_reg - utcc_pkg::month_offset(mo_c) + 9'd1);
        month_c = late_c ? (mo_c - 4'd9) : (mo_c + 4'd3);
        year_c  = 16'(s9_cent_reg) * 16'd100 + 16'(s9_yr_reg) + 16'(late_c)
                  - utcc_pkg::YEAR_BASE;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_ut_reg   <= unix_seconds;
            s0_pday_reg <= 51'(unix_seconds[31:7]) * 51'(utcc_pkg::DAY_RCP);
        end
        if (en[1])
        begin
            s1_ut_reg   <= s0_ut_reg;
            s1_days_reg <= days_c;
        end
        if (en[2])
        begin
            s2_ut_reg  <= s1_ut_reg;
            s2_rem_reg <= rem_c;
            s2_jx_reg  <= jx_c;
            s2_wx_reg  <= wx_c;
            s2_pwd_reg <= 34'(wx_c) * 34'(utcc_pkg::WD_RCP);
        end
        if (en[3])
        begin
            s3_ut_reg    <= s2_ut_reg;
            s3_rem_reg   <= s2_rem_reg;
            s3_jday_reg  <= s2_jx_reg[23:2];
            s3_phr_reg   <= 27'(s2_rem_reg[16:4]) * 27'(utcc_pkg::HOUR_RCP);
            s3_pcent_reg <= 49'(s2_jx_reg) * 49'(utcc_pkg::CENT_RCP);
            s3_wd_reg    <= wd_c;
        end
        if (en[4])
        begin
            s4_ut_reg   <= s3_ut_reg;
            s4_rem_reg  <= s3_rem_reg;
            s4_jday_reg <= s3_jday_reg;
            s4_hour_reg <= hour_c;
            s4_cent_reg <= cent_c;
            s4_wd_reg   <= s3_wd_reg;
        end
        if (en[5])
        begin
            s5_ut_reg   <= s4_ut_reg;
            s5_rsec_reg <= rsec_c;
            s5_jcen_reg <= jcen_c;
            s5_hour_reg <= s4_hour_reg;
            s5_cent_reg <= s4_cent_reg;
            s5_wd_reg   <= s4_wd_reg;
        end
        if (en[6])
        begin
            s6_ut_reg   <= s5_ut_reg;
            s6_rsec_reg <= s5_rsec_reg;
            s6_jcen_reg <= s5_jcen_reg;
            s6_hour_reg <= s5_hour_reg;
            s6_cent_reg <= s5_cent_reg;
            s6_wd_reg   <= s5_wd_reg;
            s6_pmin_reg <= 21'(s5_rsec_reg[11:2]) * 21'(utcc_pkg::MIN_RCP);
            s6_pyr_reg  <= 37'({s5_jcen_reg, 2'b11}) * 37'(utcc_pkg::YR_RCP);
        end
        if (en[7])
        begin
            s7_ut_reg   <= s6_ut_reg;
            s7_rsec_reg <= s6_rsec_reg;
            s7_jcen_reg <= s6_jcen_reg;
            s7_hour_reg <= s6_hour_reg;
            s7_cent_reg <= s6_cent_reg;
            s7_wd_reg   <= s6_wd_reg;
            s7_min_reg  <= min_c;
            s7_yr_reg   <= yr_c;
        end
        if (en[8])
        begin
            s8_ut_reg   <= s7_ut_reg;
            s8_sec_reg  <= sec_c;
            s8_min_reg  <= s7_min_reg;
            s8_hour_reg <= s7_hour_reg;
            s8_wd_reg   <= s7_wd_reg;
            s8_cent_reg <= s7_cent_reg;
            s8_yr_reg   <= s7_yr_reg;
            s8_jyr_reg  <= jyr_c;
        end
        if (en[9])
        begin
            s9_ut_reg   <= s8_ut_reg;
            s9_sec_reg  <= s8_sec_reg;
            s9_min_reg  <= s8_min_reg;
            s9_hour_reg <= s8_hour_reg;
            s9_wd_reg   <= s8_wd_reg;
            s9_cent_reg <= s8_cent_reg;
            s9_yr_reg   <= s8_yr_reg;
            s9_jyr_reg  <= s8_jyr_reg;
            s9_pmo_reg  <= 23'(xmo_c) * 23'(utcc_pkg::MO_RCP);
        end
        if (en[10])
        begin
            res_reg.unix_seconds <= s9_ut_reg;
            res_reg.second       <= s9_sec_reg;
            res_reg.minute       <= s9_min_reg;
            res_reg.hour         <= s9_hour_reg;
            res_reg.weekday      <= s9_wd_reg;
            res_reg.day          <= day_c;
            res_reg.month        <= month_c;
            res_reg.year         <= year_c[7:0];
        end
    end

    assign res = res_reg;

endmodule

[rtl/utcc_to_sec.sv]
// Calendar-to-seconds datapath plus the transfer's echo fields and action bit.
// Depends on utcc_pkg (constants, result_t, month_offset).
module utcc_to_sec (
    input  logic                         clk,
    input  logic [utcc_pkg::NSTAGES-1:0] en,
    input  logic                         action,
    input  logic [5:0]                   second_in,
    input  logic [5:0]                   minute_in,
    input  logic [4:0]                   hour_in,
    input  logic [4:0]                   day_in,
    input  logic [3:0]                   month_in,
    input  logic [6:0]                   year_in,
    output logic                         action_out,
    output utcc_pkg::result_t            res
);

    typedef struct packed {
        logic        action;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [6:0]  year;
        logic [31:0] secs;
    } item_t;

    item_t echo_reg [utcc_pkg::NSTAGES];

    logic [12:0] s0_y_reg;
    logic [8:0]  s0_off_reg;

    logic [22:0] s1_p100_reg;
    logic [22:0] s1_p400_reg;
    logic [21:0] s1_d365_reg;
    logic [10:0] s1_yq_reg;
    logic [8:0]  s1_off_reg;
    logic [16:0] s1_tod_reg;

    logic [16:0] s2_dsum_reg;
    logic [16:0] s2_tod_reg;

    logic [31:0] s3_psec_reg;
    logic [16:0] s3_tod_reg;

    logic [4:0]  adj_c;
    logic [3:0]  mar_c;
    logic [31:0] dsum_c;
    item_t       sec_item_c;

    // March-based month; months 1 and 2 (and 0) belong to the previous year
    always_comb
    begin
        case (month_in)
            4'd0, 4'd1, 4'd2:
            begin
                adj_c = 5'd1;
                mar_c = month_in + 4'd9;
            end
            4'd15:
            begin
                adj_c = 5'd21;
                mar_c = 4'd8;
            end
            default:
            begin
                adj_c = 5'd0;
                mar_c = month_in - 4'd3;
            end
        endcase
    end

    always_comb
    begin
        dsum_c = 32'(echo_reg[1].day) + 32'(s1_off_reg) + 32'(s1_d365_reg)
                 + 32'(s1_yq_reg) - 32'(s1_p100_reg >> utcc_pkg::D25_SH)
                 + 32'(s1_p400_reg >> utcc_pkg::D25_SH) - utcc_pkg::JDN_UNIX_BASE;
    end

    always_comb
    begin
        sec_item_c      = echo_reg[utcc_pkg::SEC_STAGE-1];
        sec_item_c.secs = s3_psec_reg + 32'(s3_tod_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            echo_reg[0].action <= action;
            echo_reg[0].second <= second_in;
            echo_reg[0].minute <= minute_in;
            echo_reg[0].hour   <= hour_in;
            echo_reg[0].day    <= day_in;
            echo_reg[0].month  <= month_in;
            echo_reg[0].year   <= year_in;
            echo_reg[0].secs   <= '0;
            s0_y_reg   <= 13'(16'(year_in) + utcc_pkg::YEAR_BASE - 16'(adj_c));
            s0_off_reg <= utcc_pkg::month_offset(mar_c);
        end
        if (en[1])
        begin
            s1_p100_reg <= 23'(s0_y_reg[12:2]) * 23'(utcc_pkg::D25_RCP);
            s1_p400_reg <= 23'(s0_y_reg[12:4]) * 23'(utcc_pkg::D25_RCP);
            s1_d365_reg <= 22'(s0_y_reg) * 22'd365;
            s1_yq_reg   <= s0_y_reg[12:2];
            s1_off_reg  <= s0_off_reg;
            s1_tod_reg  <= 17'(echo_reg[0].hour) * 17'd3600
                           + 17'(echo_reg[0].minute) * 17'd60
                           + 17'(echo_reg[0].second);
        end
        if (en[2])
        begin
            s2_dsum_reg <= dsum_c[16:0];
            s2_tod_reg  <= s1_tod_reg;
        end
        if (en[3])
        begin
            s3_psec_reg <= 32'(34'(s2_dsum_reg) * 34'(utcc_pkg::SECS_PER_DAY));
            s3_tod_reg  <= s2_tod_reg;
        end
        for (int s = 1; s < utcc_pkg::NSTAGES; s++)
        begin
            if (en[s])
            begin
                echo_reg[s] <= (s == utcc_pkg::SEC_STAGE) ? sec_item_c : echo_reg[s-1];
            end
        end
    end

    assign action_out       = echo_reg[utcc_pkg::NSTAGES-1].action;
    assign res.unix_seconds = echo_reg[utcc_pkg::NSTAGES-1].secs;
    assign res.second       = echo_reg[utcc_pkg::NSTAGES-1].second;
    assign res.minute       = echo_reg[utcc_pkg::NSTAGES-1].minute;
    assign res.hour         = echo_reg[utcc_pkg::NSTAGES-1].hour;
    assign res.weekday      = 3'd0;
    assign res.day          = echo_reg[utcc_pkg::NSTAGES-1].day;
    assign res.month        = echo_reg[utcc_pkg::NSTAGES-1].month;
    assign res.year         = 8'(echo_reg[utcc_pkg::NSTAGES-1].year);

endmodule

[rtl/unix_time_calendar_converter_top.sv]
// Unix time / calendar converter, 11-stage pipeline. Every transfer runs through both
// directions side by side and the action bit picks the result at the output. One
// transfer per cycle is accepted and delivered while the response side is ready. Each
// stage holds at most two reciprocal multiplies (the widest are 25x26 for the day split
// and 24x25 for the century step), which sets the clock. Per-stage valid bits let a new
// request enter while a finished result waits, as long as some stage is empty; with the
// response side ready the block never stalls the request side.
// Depends on utcc_pkg, utcc_ctrl, utcc_to_cal and utcc_to_sec.
module unix_time_calendar_converter_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic        action,
    input  logic [31:0] unix_seconds,
    input  logic [5:0]  second_in,
    input  logic [5:0]  minute_in,
    input  logic [4:0]  hour_in,
    input  logic [4:0]  day_in,
    input  logic [3:0]  month_in,
    input  logic [6:0]  year_in,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [31:0] unix_seconds_out,
    output logic [5:0]  second_out,
    output logic [5:0]  minute_out,
    output logic [4:0]  hour_out,
    output logic [2:0]  weekday_out,
    output logic [4:0]  day_out,
    output logic [3:0]  month_out,
    output logic [7:0]  year_out
);

    logic [utcc_pkg::NSTAGES-1:0] en;
    utcc_pkg::result_t            cal_res;
    utcc_pkg::result_t            sec_res;
    utcc_pkg::result_t            res;
    logic                         res_action;

    utcc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .en        (en)
    );

    utcc_to_cal u_to_cal (
        .clk          (clk),
        .en           (en),
        .unix_seconds (unix_seconds),
        .res          (cal_res)
    );

    utcc_to_sec u_to_sec (
        .clk        (clk),
        .en         (en),
        .action     (action),
        .second_in  (second_in),
        .minute_in  (minute_in),
        .hour_in    (hour_in),
        .day_in     (day_in),
        .month_in   (month_in),
        .year_in    (year_in),
        .action_out (res_action),
        .res        (sec_res)
    );

    assign res = res_action ? sec_res : cal_res;

    assign unix_seconds_out = res.unix_seconds;
    assign second_out       = res.second;
    assign minute_out       = res.minute;
    assign hour_out         = res.hour;
    assign weekday_out      = res.weekday;
    assign day_out          = res.day;
    assign month_out        = res.month;
    assign year_out         = res.year;

endmodule

[rtl/utcc_checker.sv]
// Port-level checks for the converter and the bind that attaches them to the top level.
// Depends on unix_time_calendar_converter_top port names only.
module utcc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [31:0] unix_seconds_out,
    input logic [5:0]  second_out,
    input logic [5:0]  minute_out,
    input logic [4:0]  hour_out,
    input logic [2:0]  weekday_out,
    input logic [4:0]  day_out,
    input logic [3:0]  month_out,
    input logic [7:0]  year_out
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(unix_seconds_out)
            && $stable(second_out) && $stable(minute_out) && $stable(hour_out)
            && $stable(weekday_out) && $stable(day_out) && $stable(month_out)
            && $stable(year_out))
        else $error("response changed while stalled");

    // an open output slot always propagates back to the request side
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!rsp_valid || rsp_ready) |-> req_ready)
        else $error("request stalled with output free");

    a_weekday_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> weekday_out <= 3'd6)
        else $error("weekday out of range");

    // nonzero weekday only comes from the seconds-to-calendar path
    a_cal_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && weekday_out != 3'd0 |-> second_out <= 6'd59 && minute_out <= 6'd59
            && hour_out <= 5'd23 && day_out >= 5'd1 && month_out >= 4'd1
            && month_out <= 4'd12)
        else $error("calendar field out of range");

endmodule

bind unix_time_calendar_converter_top utcc_checker u_utcc_checker (.*);
